/* src/shell_line_tokenizer_top_defines.svh */
// assertion macros shared by the tokenizer rtl
`ifndef SHELL_LINE_TOKENIZER_TOP_DEFINES_SVH
`define SHELL_LINE_TOKENIZER_TOP_DEFINES_SVH

// condition in the same cycle implies the consequent
`define SLT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slt assertion failed");

// condition implies the consequent in the next cycle
`define SLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slt assertion failed");

`endif

/* src/slt_pkg.sv */
// shared types, codes and character constants of the line tokenizer
package slt_pkg;

    localparam int TOKEN_BUFFER_BYTES = 64;
    localparam int QUEUE_DEPTH        = 4;

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_BARE   = 2'd1;
    localparam logic [1:0] MODE_QUOTED = 2'd2;

    localparam logic [2:0] KIND_BYTE = 3'd0;
    localparam logic [2:0] KIND_EOS  = 3'd1;
    localparam logic [2:0] KIND_LT   = 3'd2;
    localparam logic [2:0] KIND_GT   = 3'd3;
    localparam logic [2:0] KIND_PIPE = 3'd4;
    localparam logic [2:0] KIND_AT   = 3'd5;
    localparam logic [2:0] KIND_EOL  = 3'd6;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic       last;
    } t_result;

    // what one word produces: up to two results and the next mode
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
        logic [1:0] mode_next;
    } t_decode;

    // token kind of a single-character delimiter, KIND_BYTE when not one
    function automatic logic [2:0] single_kind(input logic [7:0] b);
        logic [2:0] k;
        k = KIND_BYTE;
        if (b == CH_LT) k = KIND_LT;
        else if (b == CH_GT) k = KIND_GT;
        else if (b == CH_PIPE) k = KIND_PIPE;
        else if (b == CH_AT) k = KIND_AT;
        return k;
    endfunction

endpackage

/* src/slt_decode.sv */
// per-word lexing decision: results and next state from one byte
module slt_decode #(
    parameter int TOKEN_BUFFER_BYTES = slt_pkg::TOKEN_BUFFER_BYTES,
    localparam int LEN_W = $clog2(TOKEN_BUFFER_BYTES - 1)
) (
    input  logic [7:0]       i_byte,
    input  logic [1:0]       i_mode,
    input  logic [LEN_W-1:0] i_len,
    output slt_pkg::t_decode o_dec,
    output logic [LEN_W-1:0] o_len_next
);

    // a fresh bare string of one byte already at the cap
    localparam bit FreshCap = (TOKEN_BUFFER_BYTES - 1) <= 1;

    logic [2:0]       sk;
    logic             is_single;
    logic             is_blank;
    logic             is_quote;
    logic             is_zero;
    logic             cap;
    slt_pkg::t_decode d;
    logic [LEN_W-1:0] len_n;

    always_comb begin
        sk        = slt_pkg::single_kind(i_byte);
        is_single = sk != slt_pkg::KIND_BYTE;
        is_blank  = (i_byte == slt_pkg::CH_SPACE) || (i_byte == slt_pkg::CH_TAB);
        is_quote  = i_byte == slt_pkg::CH_QUOTE;
        is_zero   = i_byte == slt_pkg::CH_NUL;
        cap       = i_len == LEN_W'(TOKEN_BUFFER_BYTES - 2);

        d.cnt        = 2'd0;
        d.res0       = '{kind: slt_pkg::KIND_EOS, value: 8'h00, last: 1'b0};
        d.res1       = '{kind: slt_pkg::KIND_EOS, value: 8'h00, last: 1'b0};
        d.mode_next  = slt_pkg::MODE_IDLE;
        len_n        = '0;

        unique case (i_mode)
            slt_pkg::MODE_BARE: begin
                if (is_zero || is_single || is_blank || is_quote) begin
                    // close the string, then treat the byte as in idle
                    d.cnt = 2'd1;
                    if (is_zero) begin
                        d.cnt       = 2'd2;
                        d.res1.kind = slt_pkg::KIND_EOL;
                    end else if (is_single) begin
                        d.cnt        = 2'd2;
                        d.res1.kind  = sk;
                        d.res1.value = i_byte;
                    end else if (is_quote) begin
                        d.mode_next = slt_pkg::MODE_QUOTED;
                    end
                end else begin
                    d.res0.kind  = slt_pkg::KIND_BYTE;
                    d.res0.value = i_byte;
                    if (cap) begin
                        d.cnt = 2'd2;
                    end else begin
                        d.cnt       = 2'd1;
                        d.mode_next = slt_pkg::MODE_BARE;
                        len_n       = i_len + LEN_W'(1);
                    end
                end
            end
            slt_pkg::MODE_QUOTED: begin
                if (is_quote) begin
                    d.cnt = 2'd1;
                end else if (is_zero) begin
                    d.cnt       = 2'd2;
                    d.res1.kind = slt_pkg::KIND_EOL;
                end else begin
                    d.res0.kind  = slt_pkg::KIND_BYTE;
                    d.res0.value = i_byte;
                    if (cap) begin
                        d.cnt = 2'd2;
                    end else begin
                        d.cnt       = 2'd1;
                        d.mode_next = slt_pkg::MODE_QUOTED;
                        len_n       = i_len + LEN_W'(1);
                    end
                end
            end
            default: begin
                if (is_zero) begin
                    d.cnt       = 2'd1;
                    d.res0.kind = slt_pkg::KIND_EOL;
                end else if (is_single) begin
                    d.cnt        = 2'd1;
                    d.res0.kind  = sk;
                    d.res0.value = i_byte;
                end else if (is_blank) begin
                    d.cnt = 2'd0;
                end else if (is_quote) begin
                    d.mode_next = slt_pkg::MODE_QUOTED;
                end else begin
                    d.res0.kind  = slt_pkg::KIND_BYTE;
                    d.res0.value = i_byte;
                    if (FreshCap) begin
                        d.cnt = 2'd2;
                    end else begin
                        d.cnt       = 2'd1;
                        d.mode_next = slt_pkg::MODE_BARE;
                        len_n       = LEN_W'(1);
                    end
                end
            end
        endcase

        d.res0.last = d.cnt == 2'd1;
        d.res1.last = d.cnt == 2'd2;
    end

    assign o_dec      = d;
    assign o_len_next = len_n;

endmodule

/* src/shell_line_tokenizer_top.sv */
// shell command line tokenizer: one character word in, token words out
//
//   channel | valid      | stall      | payload
//   --------+------------+------------+------------------------------
//   in      | i_in_valid | o_in_stall | i_byte_req
//   out     | o_out_valid| i_out_stall| o_kind, o_value, o_last
//
// one input word is lexed in the cycle it is accepted; its 0..2 results
// enter a 4-entry result queue that drives the output ports
// one word per cycle while words give at most one result each and the
// output is not stalled; the two results of one word leave the queue in turn
// input stalls while fewer than two queue entries are free
// synchronous active-low reset empties the queue and returns to idle
`include "shell_line_tokenizer_top_defines.svh"

module shell_line_tokenizer_top #(
    parameter int TOKEN_BUFFER_BYTES = slt_pkg::TOKEN_BUFFER_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_byte_req,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_kind,
    output logic [7:0] o_value,
    output logic       o_last
);

    localparam int LEN_W   = $clog2(TOKEN_BUFFER_BYTES - 1);
    localparam int DEPTH   = slt_pkg::QUEUE_DEPTH;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    logic [1:0]       r_mode;
    logic [LEN_W-1:0] r_len;
    slt_pkg::t_result r_q [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    slt_pkg::t_decode dec;
    logic [LEN_W-1:0] len_next;
    logic             in_acc;
    logic             pop;
    logic [1:0]       push_n;
    logic [CNT_W-1:0] n_cnt;
    slt_pkg::t_result head;

    slt_decode #(
        .TOKEN_BUFFER_BYTES(TOKEN_BUFFER_BYTES)
    ) u_decode (
        .i_byte    (i_byte_req),
        .i_mode    (r_mode),
        .i_len     (r_len),
        .o_dec     (dec),
        .o_len_next(len_next)
    );

    assign o_in_stall  = r_cnt > CNT_W'(DEPTH - 2);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_cnt != '0;
    assign pop         = o_out_valid && !i_out_stall;
    assign push_n      = in_acc ? dec.cnt : 2'd0;
    assign n_cnt       = r_cnt + CNT_W'(push_n) - CNT_W'(pop);

    assign head    = r_q[r_rd];
    assign o_kind  = head.kind;
    assign o_value = head.value;
    assign o_last  = head.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= slt_pkg::MODE_IDLE;
            r_len  <= '0;
            r_wr   <= '0;
            r_rd   <= '0;
            r_cnt  <= '0;
        end else begin
            if (in_acc) begin
                r_mode <= dec.mode_next;
                r_len  <= len_next;
            end
            r_wr  <= r_wr + PTR_W'(push_n);
            r_rd  <= r_rd + PTR_W'(pop);
            r_cnt <= n_cnt;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_q[r_wr] <= dec.res0;
        end
        if (push_n == 2'd2) begin
            r_q[r_wr + PTR_W'(1)] <= dec.res1;
        end
    end

    `SLT_ASSERT_IMP(a_cnt_max, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(DEPTH))
    `SLT_ASSERT_IMP(a_len_cap, i_clk, i_rst_n, 1'b1,
                    r_len <= LEN_W'(TOKEN_BUFFER_BYTES - 2))
    `SLT_ASSERT_NEXT(a_eol_idle, i_clk, i_rst_n,
                     in_acc && (i_byte_req == slt_pkg::CH_NUL),
                     r_mode == slt_pkg::MODE_IDLE)
    `SLT_ASSERT_IMP(a_eol_last, i_clk, i_rst_n,
                    o_out_valid && (o_kind == slt_pkg::KIND_EOL), o_last)

endmodule
